### rtl/core/ivdf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ivdf_pkg
// Shared constants and types for the inverse-variance depth fusion unit.
// ----------------------------------------------------------------------------
package ivdf_pkg;

    localparam int VAL_W   = 16;
    localparam int QUO_W   = 16;
    localparam int CFG_IDX_W = 1;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_USE_PIXEL_VAR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_PRED_VAR = 1'd1;

    localparam logic [VAL_W-1:0] FIXED_PRED_VAR_RST = 16'd4096;

    // 2^20: one in Q4.12 divided into one in Q8.8.
    localparam logic [20:0] DEPTH_NUM = 21'd1048576;
    // Inverse depths at or below this value give a depth of 2^16 or more.
    localparam logic [VAL_W-1:0] DEPTH_SAT_LIMIT = 16'd16;

    // Input register, products, dividends, 16 fusion divider stages, case
    // select, 16 depth divider stages, output register.
    localparam int LATENCY = 37;

    localparam logic [1:0] SRC_MERGED  = 2'd0;
    localparam logic [1:0] SRC_PROJ    = 2'd1;
    localparam logic [1:0] SRC_PRED    = 2'd2;
    localparam logic [1:0] SRC_INVALID = 2'd3;

    typedef struct packed {
        logic             pj_ok;
        logic             pd_ok;
        logic             sum_zero;
        logic [VAL_W-1:0] pj;
        logic [VAL_W-1:0] pj_var;
        logic [VAL_W-1:0] pd;
        logic [VAL_W-1:0] pd_var;
    } fuse_side_t;

    typedef struct packed {
        logic             valid;
        logic             sat;
        logic [1:0]       src;
        logic [VAL_W-1:0] idepth;
        logic [VAL_W-1:0] var_out;
    } depth_side_t;

endpackage

`default_nettype wire

### rtl/core/inverse_variance_depth_fusion_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// inverse_variance_depth_fusion_unit
// Fuses a propagated and a predicted inverse-depth hypothesis per pixel and
// gives the fused inverse depth, its variance and the depth as reciprocal.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  input    | start, busy            | proj_*, pred_* fields
//  result   | done (one-cycle strobe)| fused_idepth, fused_variance,
//           |                        | pixel_valid, depth_out, source_case
//  config   | cfg_we                 | cfg_index, cfg_data
//
//  One item enters every cycle; busy is always low.
//  From start to done each item passes through two chains of 16
//  one-bit-per-stage restoring divider stages.
//  Reset clears the stage valid bits and the config registers, not the data.
//  The receiver cannot stall, so the pipeline advances on every clock.
// ----------------------------------------------------------------------------
module inverse_variance_depth_fusion_unit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [ivdf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]                cfg_data,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic                       proj_valid,
    input  wire logic signed [15:0]         proj_idepth,
    input  wire logic [15:0]                proj_variance,
    input  wire logic                       pred_present,
    input  wire logic signed [15:0]         pred_idepth,
    input  wire logic [15:0]                pred_variance,
    output logic                            done,
    output logic signed [15:0]              fused_idepth,
    output logic [15:0]                     fused_variance,
    output logic                            pixel_valid,
    output logic [15:0]                     depth_out,
    output logic [1:0]                      source_case
);
    import ivdf_pkg::*;

    logic             use_pix_reg;
    logic [VAL_W-1:0] fixed_var_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_pix_reg   <= 1'b0;
            fixed_var_reg <= FIXED_PRED_VAR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_USE_PIXEL_VAR:  use_pix_reg   <= cfg_data[0];
                REG_FIXED_PRED_VAR: fixed_var_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Stage A: input register with usability flags.
    logic       a_vld_reg;
    fuse_side_t a_reg;

    // Stage B: products.
    logic        b_vld_reg;
    fuse_side_t  b_reg;
    logic [31:0] b_p1_reg, b_p2_reg, b_pv_reg;

    // Fusion divider chain; index 0 is loaded with the dividends.
    logic             f_vld_reg [0:QUO_W];
    fuse_side_t       f_side_reg [0:QUO_W];
    logic [32:0]      f_n_reg   [0:QUO_W];
    logic [32:0]      f_v_reg   [0:QUO_W];
    logic [16:0]      f_sum_reg [0:QUO_W];
    logic [QUO_W-1:0] f_q1_reg  [0:QUO_W];
    logic [QUO_W-1:0] f_q2_reg  [0:QUO_W];

    // Depth divider chain; index 0 is loaded by the case select stage.
    logic             d_vld_reg  [0:QUO_W];
    depth_side_t      d_side_reg [0:QUO_W];
    logic [31:0]      d_n_reg    [0:QUO_W];
    logic [QUO_W-1:0] d_q_reg    [0:QUO_W];

    logic done_reg;
    logic [15:0] idepth_reg, var_reg, depth_reg;
    logic pvalid_reg;
    logic [1:0] src_reg;

    logic [16:0] b_sum;
    assign b_sum = {1'b0, b_reg.pj_var} + {1'b0, b_reg.pd_var};

    always_ff @(posedge clk)
    begin
        a_reg.pj_ok    <= proj_valid && !proj_idepth[15] && (proj_idepth != 16'sd0);
        a_reg.pd_ok    <= pred_present && !pred_idepth[15] && (pred_idepth != 16'sd0);
        a_reg.sum_zero <= (proj_variance == 16'd0)
                          && ((use_pix_reg ? pred_variance : fixed_var_reg) == 16'd0);
        a_reg.pj       <= proj_idepth;
        a_reg.pj_var   <= proj_variance;
        a_reg.pd       <= pred_idepth;
        a_reg.pd_var   <= use_pix_reg ? pred_variance : fixed_var_reg;

        b_reg    <= a_reg;
        b_p1_reg <= a_reg.pd * a_reg.pj_var;
        b_p2_reg <= a_reg.pj * a_reg.pd_var;
        b_pv_reg <= a_reg.pj_var * a_reg.pd_var;

        f_side_reg[0] <= b_reg;
        f_sum_reg[0] <= b_sum;
        f_n_reg[0]   <= {1'b0, b_p1_reg} + {1'b0, b_p2_reg} + {17'd0, b_sum[16:1]};
        f_v_reg[0]   <= {1'b0, b_pv_reg} + {17'd0, b_sum[16:1]};
        f_q1_reg[0]  <= '0;
        f_q2_reg[0]  <= '0;
    end

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_fdiv
        localparam int BIT = QUO_W - 1 - k;
        logic [32:0] shifted;
        logic        ge_n, ge_v;
        assign shifted = {16'd0, f_sum_reg[k]} << BIT;
        assign ge_n    = f_n_reg[k] >= shifted;
        assign ge_v    = f_v_reg[k] >= shifted;

        always_ff @(posedge clk)
        begin
            f_side_reg[k+1] <= f_side_reg[k];
            f_sum_reg[k+1]  <= f_sum_reg[k];
            f_n_reg[k+1]    <= ge_n ? f_n_reg[k] - shifted : f_n_reg[k];
            f_v_reg[k+1]    <= ge_v ? f_v_reg[k] - shifted : f_v_reg[k];
            f_q1_reg[k+1]   <= f_q1_reg[k] | (QUO_W'(ge_n) << BIT);
            f_q2_reg[k+1]   <= f_q2_reg[k] | (QUO_W'(ge_v) << BIT);
        end
    end

    // Case select on the finished fusion quotients.
    fuse_side_t  e_side;
    depth_side_t e_next;
    always_comb
    begin
        e_side = f_side_reg[QUO_W];
        e_next = '0;
        priority if (e_side.pj_ok && e_side.pd_ok && !e_side.sum_zero)
        begin
            e_next.valid   = 1'b1;
            e_next.src     = SRC_MERGED;
            e_next.idepth  = f_q1_reg[QUO_W][15] ? 16'd32767 : f_q1_reg[QUO_W];
            e_next.var_out = f_q2_reg[QUO_W];
        end
        else if (e_side.pj_ok)
        begin
            e_next.valid   = 1'b1;
            e_next.src     = SRC_PROJ;
            e_next.idepth  = e_side.pj;
            e_next.var_out = e_side.pj_var;
        end
        else if (e_side.pd_ok)
        begin
            e_next.valid   = 1'b1;
            e_next.src     = SRC_PRED;
            e_next.idepth  = e_side.pd;
            e_next.var_out = e_side.pd_var;
        end
        else
        begin
            e_next.src = SRC_INVALID;
        end
        e_next.sat = e_next.idepth <= DEPTH_SAT_LIMIT;
    end

    always_ff @(posedge clk)
    begin
        d_side_reg[0] <= e_next;
        d_n_reg[0]    <= {11'd0, DEPTH_NUM + {6'd0, e_next.idepth[15:1]}};
        d_q_reg[0]    <= '0;
    end

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_ddiv
        localparam int BIT = QUO_W - 1 - k;
        logic [31:0] shifted;
        logic        ge;
        assign shifted = {16'd0, d_side_reg[k].idepth} << BIT;
        assign ge      = d_n_reg[k] >= shifted;

        always_ff @(posedge clk)
        begin
            d_side_reg[k+1] <= d_side_reg[k];
            d_n_reg[k+1]    <= ge ? d_n_reg[k] - shifted : d_n_reg[k];
            d_q_reg[k+1]    <= d_q_reg[k] | (QUO_W'(ge) << BIT);
        end
    end

    always_ff @(posedge clk)
    begin
        idepth_reg <= d_side_reg[QUO_W].idepth;
        var_reg    <= d_side_reg[QUO_W].var_out;
        pvalid_reg <= d_side_reg[QUO_W].valid;
        src_reg    <= d_side_reg[QUO_W].src;
        if (!d_side_reg[QUO_W].valid)
            depth_reg <= '0;
        else if (d_side_reg[QUO_W].sat)
            depth_reg <= 16'hFFFF;
        else
            depth_reg <= d_q_reg[QUO_W];
    end

    // Valid bits travel alongside the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            done_reg  <= 1'b0;
            for (int i = 0; i <= QUO_W; i++)
            begin
                f_vld_reg[i] <= 1'b0;
                d_vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            a_vld_reg    <= start;
            b_vld_reg    <= a_vld_reg;
            f_vld_reg[0] <= b_vld_reg;
            d_vld_reg[0] <= f_vld_reg[QUO_W];
            for (int i = 0; i < QUO_W; i++)
            begin
                f_vld_reg[i+1] <= f_vld_reg[i];
                d_vld_reg[i+1] <= d_vld_reg[i];
            end
            done_reg <= d_vld_reg[QUO_W];
        end
    end

    assign done           = done_reg;
    assign fused_idepth   = idepth_reg;
    assign fused_variance = var_reg;
    assign pixel_valid    = pvalid_reg;
    assign depth_out      = depth_reg;
    assign source_case    = src_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $past(start, LATENCY) |-> done)
        else $error("item did not come out after the pipeline latency");

    a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (pixel_valid == (source_case != SRC_INVALID)))
        else $error("pixel_valid disagrees with source_case");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !pixel_valid) |-> (fused_idepth == 16'sd0 && depth_out == 16'd0
                                    && fused_variance == 16'd0))
        else $error("invalid pixel carries nonzero fields");

    a_valid_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (done && pixel_valid) |-> (fused_idepth > 16'sd0 && depth_out != 16'd0))
        else $error("valid pixel has non-positive inverse depth or zero depth");

endmodule

`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the inverse-variance depth fusion unit. Pixels are
// driven with random gaps, each accepted pixel is predicted in the bench and
// every done strobe is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import ivdf_pkg::*;

    typedef struct packed {
        logic        pj_valid;
        logic [15:0] pj;
        logic [15:0] pj_var;
        logic        pd_present;
        logic [15:0] pd;
        logic [15:0] pd_var;
    } pixel_t;

    typedef struct packed {
        logic [15:0] idepth;
        logic [15:0] variance;
        logic        valid;
        logic [15:0] depth;
        logic [1:0]  src;
    } fusion_t;

    class fusion_scoreboard;
        fusion_t pending[$];
        bit      per_pixel_var;
        bit [15:0] fixed_var;
        int      errors;
        int      merged_seen;
        int      checked;

        function bit [15:0] recip_depth(bit [15:0] id);
            bit [31:0] q;
            if (id == 0)
                return 16'd0;
            q = (32'd1048576 + id / 2) / id;
            return (q > 65535) ? 16'hFFFF : q[15:0];
        endfunction

        function void note_pixel(pixel_t p);
            fusion_t r;
            bit [15:0] pdv;
            bit pj_ok;
            bit pd_ok;
            bit [63:0] sum;
            bit [63:0] num;
            bit [63:0] m;
            bit [63:0] v;
            pdv = per_pixel_var ? p.pd_var : fixed_var;
            pj_ok = p.pj_valid && ($signed(p.pj) > 0);
            pd_ok = p.pd_present && ($signed(p.pd) > 0);
            sum = 64'(p.pj_var) + 64'(pdv);
            r = '0;
            r.src = SRC_INVALID;
            if (pj_ok && pd_ok && sum != 0) begin
                num = 64'(p.pd) * 64'(p.pj_var) + 64'(p.pj) * 64'(pdv);
                m = (num + sum / 2) / sum;
                v = (64'(p.pj_var) * 64'(pdv) + sum / 2) / sum;
                r.idepth = (m > 32767) ? 16'h7FFF : m[15:0];
                r.variance = (v > 65535) ? 16'hFFFF : v[15:0];
                r.valid = 1;
                r.src = SRC_MERGED;
            end
            else if (pj_ok) begin
                r.idepth = p.pj;
                r.variance = p.pj_var;
                r.valid = 1;
                r.src = SRC_PROJ;
            end
            else if (pd_ok) begin
                r.idepth = p.pd;
                r.variance = pdv;
                r.valid = 1;
                r.src = SRC_PRED;
            end
            if (r.valid)
                r.depth = recip_depth(r.idepth);
            pending.push_back(r);
        endfunction

        function void check_result(fusion_t got);
            fusion_t exp_r;
            if (pending.size() == 0) begin
                $error("result with nothing pending");
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            checked++;
            if (exp_r.src == SRC_MERGED)
                merged_seen++;
            if (got.idepth !== exp_r.idepth) begin
                $error("fused_idepth exp %0h got %0h", exp_r.idepth, got.idepth);
                errors++;
            end
            if (got.variance !== exp_r.variance) begin
                $error("fused_variance exp %0h got %0h", exp_r.variance, got.variance);
                errors++;
            end
            if (got.valid !== exp_r.valid) begin
                $error("pixel_valid exp %0b got %0b", exp_r.valid, got.valid);
                errors++;
            end
            if (got.depth !== exp_r.depth) begin
                $error("depth_out exp %0h got %0h", exp_r.depth, got.depth);
                errors++;
            end
            if (got.src !== exp_r.src) begin
                $error("source_case exp %0d got %0d", exp_r.src, got.src);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic start = 0;
    logic busy;
    pixel_t pix = '0;
    logic done;
    logic signed [15:0] fused_idepth;
    logic [15:0] fused_variance;
    logic pixel_valid;
    logic [15:0] depth_out;
    logic [1:0] source_case;

    fusion_scoreboard sb;

    inverse_variance_depth_fusion_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .start(start), .busy(busy),
        .proj_valid(pix.pj_valid), .proj_idepth(pix.pj), .proj_variance(pix.pj_var),
        .pred_present(pix.pd_present), .pred_idepth(pix.pd),
        .pred_variance(pix.pd_var),
        .done(done), .fused_idepth(fused_idepth), .fused_variance(fused_variance),
        .pixel_valid(pixel_valid), .depth_out(depth_out), .source_case(source_case)
    );

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result({fused_idepth, fused_variance, pixel_valid,
                             depth_out, source_case});
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 0;
        if (idx == REG_USE_PIXEL_VAR)
            sb.per_pixel_var = val[0];
        else
            sb.fixed_var = val;
    endtask

    // Drives one pixel; start stays high across back-to-back items.
    task automatic send_pixel(pixel_t p, bit allow_gap);
        int gap;
        gap = 0;
        if (allow_gap) begin
            if ($urandom_range(0, 9) < 6)
                gap = 0;
            else if ($urandom_range(0, 9) < 8)
                gap = $urandom_range(1, 3);
            else
                gap = $urandom_range(10, 60);
        end
        if (gap > 0) begin
            start <= 0;
            repeat (gap) @(negedge clk);
        end
        start <= 1;
        pix <= p;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_pixel(p);
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    function automatic logic [15:0] rand_idepth();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(1, 32));
            1: return 16'($urandom_range(32760, 32767));
            2: return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(1, 32767));
        endcase
    endfunction

    function automatic logic [15:0] rand_var();
        case ($urandom_range(0, 4))
            0: return 16'd0;
            1: return 16'($urandom_range(65500, 65535));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic pixel_t rand_pixel();
        pixel_t p;
        p.pj_valid = ($urandom_range(0, 9) < 8);
        p.pd_present = ($urandom_range(0, 9) < 8);
        p.pj = rand_idepth();
        p.pd = rand_idepth();
        p.pj_var = rand_var();
        p.pd_var = rand_var();
        return p;
    endfunction

    initial
    begin
        pixel_t p;
        sb = new();
        sb.fixed_var = FIXED_PRED_VAR_RST;
        repeat (9) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: extremes, each source case, zero variance sum, saturation.
        write_reg(REG_USE_PIXEL_VAR, 16'd1);
        write_reg(REG_FIXED_PRED_VAR, 16'd0);
        send_pixel('{1'b1, 16'd4096, 16'd4096, 1'b1, 16'd8192, 16'd4096}, 0);
        send_pixel('{1'b1, 16'd1, 16'd0, 1'b1, 16'd32767, 16'd65535}, 0);
        send_pixel('{1'b1, 16'd32767, 16'd65535, 1'b1, 16'd32767, 16'd65535}, 0);
        send_pixel('{1'b1, 16'd100, 16'd0, 1'b1, 16'd200, 16'd0}, 0);
        send_pixel('{1'b1, 16'd16, 16'd7, 1'b0, 16'd500, 16'd9}, 0);
        send_pixel('{1'b1, 16'd17, 16'd7, 1'b1, 16'h8000, 16'd9}, 0);
        send_pixel('{1'b0, 16'd300, 16'd1, 1'b1, 16'd15, 16'd65535}, 0);
        send_pixel('{1'b1, 16'h0000, 16'd1, 1'b1, 16'd1, 16'd2}, 0);
        send_pixel('{1'b1, 16'hFFFF, 16'd1, 1'b0, 16'd1, 16'd2}, 0);
        send_pixel('{1'b0, 16'd5, 16'd5, 1'b0, 16'd5, 16'd5}, 0);
        send_pixel('{1'b1, 16'h8000, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF}, 0);
        drain();
        write_reg(REG_USE_PIXEL_VAR, 16'd0);
        send_pixel('{1'b1, 16'd4000, 16'd0, 1'b1, 16'd6000, 16'd123}, 0);
        send_pixel('{1'b0, 16'd4000, 16'd0, 1'b1, 16'd1, 16'd123}, 0);
        drain();
        write_reg(REG_FIXED_PRED_VAR, 16'hFFFF);
        send_pixel('{1'b1, 16'd4000, 16'd1, 1'b1, 16'd6000, 16'd0}, 0);
        send_pixel('{1'b0, 16'd4000, 16'd1, 1'b1, 16'd20000, 16'd0}, 0);
        drain();

        // Random phases across register settings.
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_USE_PIXEL_VAR, 16'($urandom_range(0, 1)));
            case (ph)
                0: write_reg(REG_FIXED_PRED_VAR, 16'd0);
                1: write_reg(REG_FIXED_PRED_VAR, 16'hFFFF);
                2: write_reg(REG_FIXED_PRED_VAR, FIXED_PRED_VAR_RST);
                default: write_reg(REG_FIXED_PRED_VAR, 16'($urandom_range(0, 65535)));
            endcase
            for (int i = 0; i < 100; i++) begin
                p = rand_pixel();
                send_pixel(p, (ph % 2 == 0) || (i > 50));
            end
            drain();
        end

        $display("tb_top: %0d pixels checked, %0d of them merged, over six settings",
                 sb.checked, sb.merged_seen);
        if (sb.errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("tb_top: errors");
        $finish;
    end
endmodule
